// File: design/precharge_contactor_sequencer_unit_macros.svh
// Assertion helpers for the precharge sequencer RTL.
`ifndef PRECHARGE_CONTACTOR_SEQUENCER_UNIT_MACROS_SVH
`define PRECHARGE_CONTACTOR_SEQUENCER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PCS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("precharge sequencer check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PCS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("precharge sequencer check failed");

`endif

// File: design/pcs_pkg.sv
`default_nettype none

package pcs_pkg;

	// Request kinds.
	localparam logic [2:0] KIND_TICK    = 3'd0;
	localparam logic [2:0] KIND_ON      = 3'd1;
	localparam logic [2:0] KIND_OFF     = 3'd2;
	localparam logic [2:0] KIND_CHG_EN  = 3'd3;
	localparam logic [2:0] KIND_CHG_DIS = 3'd4;

	// Connection codes.
	localparam logic [1:0] CONN_UNPLUGGED = 2'd0;
	localparam logic [1:0] CONN_LOAD      = 2'd1;
	localparam logic [1:0] CONN_CHARGER   = 2'd2;

	// Switch outcome codes.
	localparam logic [1:0] OUTCOME_NONE     = 2'd0;
	localparam logic [1:0] OUTCOME_ON       = 2'd1;
	localparam logic [1:0] OUTCOME_TIMEOUT  = 2'd2;

	// Configuration register indexes.
	localparam logic [1:0] REG_ARM_DELAY = 2'd0;
	localparam logic [1:0] REG_TIMEOUT   = 2'd1;
	localparam logic [1:0] REG_TOLERANCE = 2'd2;

	// Configuration reset values.
	localparam logic [7:0] ARM_DELAY_RESET = 8'd100;
	localparam logic [8:0] TIMEOUT_RESET   = 9'd250;
	localparam logic [3:0] TOLERANCE_RESET = 4'd1;

	typedef struct packed {
		logic [2:0]  kind;
		logic        key_one_level;
		logic        key_two_level;
		logic [16:0] output_voltage;
		logic [16:0] battery_voltage;
	} item_t;

	typedef struct packed {
		logic       main_relay_on;
		logic       precharge_relay_on;
		logic [1:0] connection;
		logic       precharging;
		logic [1:0] switch_outcome;
	} result_t;

	typedef struct packed {
		logic [7:0] arm_delay_ticks;
		logic [8:0] precharge_timeout_ticks;
		logic [3:0] tolerance_tenths;
	} cfg_t;

endpackage

`default_nettype wire

// File: design/pcs_ctrl.sv
`default_nettype none
`include "precharge_contactor_sequencer_unit_macros.svh"

module pcs_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             en,
	input  wire pcs_pkg::item_t   item,
	input  wire pcs_pkg::cfg_t    cfg,
	output pcs_pkg::result_t      result
);

	logic [1:0] conn_q, conn_d;
	logic [7:0] arm_count_q, arm_count_d;
	logic       auto_allowed_q, auto_allowed_d;
	logic       manual_override_q, manual_override_d;
	logic       main_relay_q, main_relay_d;
	logic       precharge_relay_q, precharge_relay_d;
	logic       precharge_active_q, precharge_active_d;
	logic [8:0] precharge_count_q, precharge_count_d;
	logic       started_auto_q, started_auto_d;

	logic        key_one;
	logic        key_two;
	logic [16:0] gap;
	logic [20:0] gap_x10;
	logic [20:0] window;
	logic        close;
	logic [8:0]  count_next;
	logic [1:0]  conn_new;
	logic        start;
	logic        start_auto;
	logic [1:0]  outcome;

	// Voltage window check: 10 * |vout - vbat| <= vbat * tolerance.
	assign key_one = !item.key_one_level;
	assign key_two = !item.key_two_level;
	assign gap = (item.output_voltage > item.battery_voltage) ?
		(item.output_voltage - item.battery_voltage) :
		(item.battery_voltage - item.output_voltage);
	assign gap_x10 = {1'b0, gap, 3'b000} + {3'b000, gap, 1'b0};
	assign window = {4'b0000, item.battery_voltage} * {17'd0, cfg.tolerance_tenths};
	assign close = (gap_x10 <= window);
	assign count_next = precharge_count_q + 9'd1;

	// Next state for the request held in the input stage.
	always_comb begin
		conn_d = conn_q;
		arm_count_d = arm_count_q;
		auto_allowed_d = auto_allowed_q;
		manual_override_d = manual_override_q;
		main_relay_d = main_relay_q;
		precharge_relay_d = precharge_relay_q;
		precharge_active_d = precharge_active_q;
		precharge_count_d = precharge_count_q;
		started_auto_d = started_auto_q;
		conn_new = conn_q;
		start = 1'b0;
		start_auto = 1'b0;
		outcome = pcs_pkg::OUTCOME_NONE;

		if (item.kind == pcs_pkg::KIND_TICK) begin
			if (precharge_active_q) begin
				// An attempt is running: count and check for timeout or success.
				precharge_count_d = count_next;
				if (count_next >= cfg.precharge_timeout_ticks) begin
					precharge_relay_d = 1'b0;
					precharge_active_d = 1'b0;
					if (started_auto_q) begin
						auto_allowed_d = 1'b0;
					end
					outcome = pcs_pkg::OUTCOME_TIMEOUT;
				end else if (close) begin
					main_relay_d = 1'b1;
					precharge_relay_d = 1'b0;
					precharge_active_d = 1'b0;
					outcome = pcs_pkg::OUTCOME_ON;
				end
			end else begin
				// Decode the keys; first key alone leaves the connection as is.
				if (!key_one && !key_two) begin
					conn_new = pcs_pkg::CONN_UNPLUGGED;
					if (!manual_override_q) begin
						main_relay_d = 1'b0;
						precharge_relay_d = 1'b0;
					end
				end else if (!key_one && key_two) begin
					conn_new = pcs_pkg::CONN_LOAD;
				end else if (key_one && key_two) begin
					conn_new = pcs_pkg::CONN_CHARGER;
				end
				conn_d = conn_new;
				if (conn_new == pcs_pkg::CONN_LOAD) begin
					if (arm_count_q < cfg.arm_delay_ticks) begin
						arm_count_d = arm_count_q + 8'd1;
					end else if (auto_allowed_q) begin
						start = 1'b1;
						start_auto = 1'b1;
					end
				end else begin
					arm_count_d = 8'd0;
					auto_allowed_d = 1'b1;
				end
			end
		end else if (!precharge_active_q) begin
			// Commands are taken only while no attempt is running.
			case (item.kind)
				pcs_pkg::KIND_ON: begin
					manual_override_d = 1'b1;
					start = 1'b1;
				end
				pcs_pkg::KIND_OFF: begin
					main_relay_d = 1'b0;
					manual_override_d = 1'b0;
				end
				pcs_pkg::KIND_CHG_EN, pcs_pkg::KIND_CHG_DIS: begin
					if (conn_q == pcs_pkg::CONN_CHARGER) begin
						main_relay_d = (item.kind == pcs_pkg::KIND_CHG_EN);
					end
				end
				default: begin
				end
			endcase
		end

		// Start of an attempt; it may finish in the same request.
		if (start) begin
			if (main_relay_q) begin
				outcome = pcs_pkg::OUTCOME_ON;
			end else begin
				precharge_relay_d = 1'b1;
				precharge_active_d = 1'b1;
				precharge_count_d = 9'd0;
				started_auto_d = start_auto;
				if (close) begin
					main_relay_d = 1'b1;
					precharge_relay_d = 1'b0;
					precharge_active_d = 1'b0;
					outcome = pcs_pkg::OUTCOME_ON;
				end
			end
		end
	end

	// Result reflects the state after this request.
	always_comb begin
		result.main_relay_on = main_relay_d;
		result.precharge_relay_on = precharge_relay_d;
		result.connection = conn_d;
		result.precharging = precharge_active_d;
		result.switch_outcome = outcome;
	end

	// State registers, updated once per request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			conn_q <= pcs_pkg::CONN_UNPLUGGED;
			arm_count_q <= 8'd0;
			auto_allowed_q <= 1'b1;
			manual_override_q <= 1'b0;
			main_relay_q <= 1'b0;
			precharge_relay_q <= 1'b0;
			precharge_active_q <= 1'b0;
			precharge_count_q <= 9'd0;
			started_auto_q <= 1'b0;
		end else if (en) begin
			conn_q <= conn_d;
			arm_count_q <= arm_count_d;
			auto_allowed_q <= auto_allowed_d;
			manual_override_q <= manual_override_d;
			main_relay_q <= main_relay_d;
			precharge_relay_q <= precharge_relay_d;
			precharge_active_q <= precharge_active_d;
			precharge_count_q <= precharge_count_d;
			started_auto_q <= started_auto_d;
		end
	end

	// The precharge relay is closed exactly while an attempt runs.
	`PCS_ASSERT_IMPLIES(a_relay_tracks_attempt, clk, arst_n, 1'b1, precharge_relay_q == precharge_active_q)
	// The main relay is never closed during an attempt.
	`PCS_ASSERT_IMPLIES(a_no_main_while_active, clk, arst_n, precharge_active_q, !main_relay_q)
	// Arm counting is frozen while an attempt runs.
	`PCS_ASSERT_NEXT(a_arm_frozen, clk, arst_n, precharge_active_q, $stable(arm_count_q))
	// A finished attempt is no longer in progress.
	`PCS_ASSERT_IMPLIES(a_outcome_ends_attempt, clk, arst_n, en && (result.switch_outcome != pcs_pkg::OUTCOME_NONE), !result.precharging)

endmodule

`default_nettype wire

// File: design/precharge_contactor_sequencer_unit.sv
// Precharge contactor sequencer.
// Path: an accepted request is held in the input register, then the control logic's result
// is held in the result register, which drives the output. Throughput: one request per
// cycle unless the receiver stalls; all state updates in a single pass of the control logic.
// Reset (arst_n low, asynchronous): relays open, unplugged, counters cleared, registers
// return to arm delay 100, timeout 250, tolerance 1.
`default_nettype none

module precharge_contactor_sequencer_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// kind[2:0]
	input  wire logic [2:0]  s_tuser,
	// key_one_level[0], key_two_level[1], output_voltage[18:2], battery_voltage[35:19],
	// zero pad[39:36]
	input  wire logic [39:0] s_tdata,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// main_relay_on[0], precharge_relay_on[1], connection[3:2], precharging[4],
	// switch_outcome[6:5], zero pad[7]
	output logic [7:0]       m_tdata,
	input  wire logic        cfg_wr_en,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [8:0]  cfg_wdata
);

	pcs_pkg::item_t   item_in;
	pcs_pkg::item_t   item_s1;
	logic             valid_s1;
	pcs_pkg::result_t result_comb;
	pcs_pkg::result_t result_s2;
	logic             valid_s2;
	pcs_pkg::cfg_t    cfg_q;
	logic             advance;
	logic             in_take;

	// Unpack the incoming request.
	always_comb begin
		item_in.kind = s_tuser;
		item_in.key_one_level = s_tdata[0];
		item_in.key_two_level = s_tdata[1];
		item_in.output_voltage = s_tdata[18:2];
		item_in.battery_voltage = s_tdata[35:19];
	end

	// Stage 1 moves on when the result register is free or being drained.
	assign advance = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign in_take = s_tvalid && s_tready;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1 <= item_in;
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.arm_delay_ticks <= pcs_pkg::ARM_DELAY_RESET;
			cfg_q.precharge_timeout_ticks <= pcs_pkg::TIMEOUT_RESET;
			cfg_q.tolerance_tenths <= pcs_pkg::TOLERANCE_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				pcs_pkg::REG_ARM_DELAY: cfg_q.arm_delay_ticks <= cfg_wdata[7:0];
				pcs_pkg::REG_TIMEOUT: cfg_q.precharge_timeout_ticks <= cfg_wdata;
				pcs_pkg::REG_TOLERANCE: cfg_q.tolerance_tenths <= cfg_wdata[3:0];
				default: begin
				end
			endcase
		end
	end

	pcs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance),
		.item   (item_s1),
		.cfg    (cfg_q),
		.result (result_comb)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result_comb;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata = {1'b0, result_s2.switch_outcome, result_s2.precharging,
		result_s2.connection, result_s2.precharge_relay_on, result_s2.main_relay_on};

endmodule

`default_nettype wire

// File: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import pcs_pkg::*;

	// Request kinds that the block has to ignore.
	localparam logic [2:0] KIND_RSVD_LO = 3'd5;
	localparam logic [2:0] KIND_RSVD_HI = 3'd7;

	// Receiver stall patterns.
	localparam int READY_ALWAYS = 0;
	localparam int READY_COIN   = 1;
	localparam int READY_SPARSE = 2;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int REPORT_LIMIT = 10;
	localparam int NUM_PHASES   = 6;

	typedef struct {
		bit          is_cfg;
		logic [1:0]  reg_idx;
		logic [8:0]  reg_val;
		logic [2:0]  kind;
		logic        lvl_one;
		logic        lvl_two;
		logic [16:0] vout;
		logic [16:0] vbat;
		bit          has_exp;
		result_t     exp_res;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [2:0]  s_tuser = '0;
	logic [39:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;
	logic        cfg_wr_en = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [8:0]  cfg_wdata = '0;

	precharge_contactor_sequencer_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tuser   (s_tuser),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Shadow copy of the sequencer state and its registers.
	cfg_t        model_cfg = '{ARM_DELAY_RESET, TIMEOUT_RESET, TOLERANCE_RESET};
	logic [1:0]  conn_q = CONN_UNPLUGGED;
	logic [7:0]  arm_cnt = '0;
	logic        auto_ok = 1'b1;
	logic        override_on = 1'b0;
	logic        main_on = 1'b0;
	logic        pre_on = 1'b0;
	logic        pre_busy = 1'b0;
	logic [8:0]  pre_cnt = '0;
	logic        pre_auto = 1'b0;

	result_t     relay_expect_q[$];
	stim_row_t   stim_table[$];
	int unsigned fail_cnt = 0;
	int unsigned cycle_cnt = 0;
	int          burst_left = 0;
	int          stall_mode = READY_ALWAYS;
	int          stall_left = 0;

	// The output side is close enough when the gap is within tolerance tenths of the battery.
	function automatic bit volts_close(input logic [16:0] vout, input logic [16:0] vbat,
			input logic [3:0] tol);
		logic [16:0] gap;
		gap = (vout > vbat) ? vout - vbat : vbat - vout;
		return (gap * 10) <= (vbat * tol);
	endfunction

	function automatic result_t relays(input logic main, input logic pre, input logic [1:0] conn,
			input logic busy, input logic [1:0] outcome);
		result_t r;
		r.main_relay_on = main;
		r.precharge_relay_on = pre;
		r.connection = conn;
		r.precharging = busy;
		r.switch_outcome = outcome;
		return r;
	endfunction

	// A precharge attempt succeeds at once if the main relay is already closed.
	task automatic start_precharge(input bit by_arm, input logic [16:0] vout,
			input logic [16:0] vbat, output logic [1:0] outcome);
		outcome = OUTCOME_NONE;
		if (main_on) begin
			outcome = OUTCOME_ON;
		end else begin
			pre_on = 1'b1;
			pre_busy = 1'b1;
			pre_cnt = '0;
			pre_auto = by_arm;
			if (volts_close(vout, vbat, model_cfg.tolerance_tenths)) begin
				main_on = 1'b1;
				pre_on = 1'b0;
				pre_busy = 1'b0;
				outcome = OUTCOME_ON;
			end
		end
	endtask

	// Advance the shadow state by one request and return the relay status it leaves.
	task automatic predict_relays(input logic [2:0] kind, input logic lvl_one,
			input logic lvl_two, input logic [16:0] vout, input logic [16:0] vbat,
			output result_t res);
		logic       key_one;
		logic       key_two;
		logic [1:0] outcome;
		key_one = !lvl_one;
		key_two = !lvl_two;
		outcome = OUTCOME_NONE;
		if (kind == KIND_TICK) begin
			if (pre_busy) begin
				// Keys are not decoded while an attempt runs.
				pre_cnt = pre_cnt + 9'd1;
				if (pre_cnt >= model_cfg.precharge_timeout_ticks) begin
					pre_on = 1'b0;
					pre_busy = 1'b0;
					if (pre_auto)
						auto_ok = 1'b0;
					outcome = OUTCOME_TIMEOUT;
				end else if (volts_close(vout, vbat, model_cfg.tolerance_tenths)) begin
					main_on = 1'b1;
					pre_on = 1'b0;
					pre_busy = 1'b0;
					outcome = OUTCOME_ON;
				end
			end else begin
				if (!key_one && !key_two) begin
					conn_q = CONN_UNPLUGGED;
					if (!override_on) begin
						main_on = 1'b0;
						pre_on = 1'b0;
					end
				end else if (!key_one && key_two) begin
					conn_q = CONN_LOAD;
				end else if (key_one && key_two) begin
					conn_q = CONN_CHARGER;
				end
				if (conn_q == CONN_LOAD) begin
					if (arm_cnt < model_cfg.arm_delay_ticks)
						arm_cnt = arm_cnt + 8'd1;
					else if (auto_ok)
						start_precharge(1'b1, vout, vbat, outcome);
				end else begin
					arm_cnt = '0;
					auto_ok = 1'b1;
				end
			end
		end else if (!pre_busy) begin
			case (kind)
				KIND_ON: begin
					override_on = 1'b1;
					start_precharge(1'b0, vout, vbat, outcome);
				end
				KIND_OFF: begin
					main_on = 1'b0;
					override_on = 1'b0;
				end
				KIND_CHG_EN, KIND_CHG_DIS: begin
					if (conn_q == CONN_CHARGER)
						main_on = (kind == KIND_CHG_EN);
				end
				default: begin
				end
			endcase
		end
		res = relays(main_on, pre_on, conn_q, pre_busy, outcome);
	endtask

	function automatic void add_row(input logic [2:0] kind, input logic lvl_one,
			input logic lvl_two, input logic [16:0] vout, input logic [16:0] vbat,
			input bit has_exp, input result_t want);
		stim_row_t row;
		row.is_cfg = 1'b0;
		row.reg_idx = '0;
		row.reg_val = '0;
		row.kind = kind;
		row.lvl_one = lvl_one;
		row.lvl_two = lvl_two;
		row.vout = vout;
		row.vbat = vbat;
		row.has_exp = has_exp;
		row.exp_res = want;
		stim_table.push_back(row);
	endfunction

	function automatic void add_cfg(input logic [1:0] idx, input logic [8:0] val);
		stim_row_t row;
		row = '{default: '0};
		row.is_cfg = 1'b1;
		row.reg_idx = idx;
		row.reg_val = val;
		stim_table.push_back(row);
	endfunction

	// Present one request in bursts with random gaps, then log what it should produce.
	task automatic drive_request(input logic [2:0] kind, input logic lvl_one,
			input logic lvl_two, input logic [16:0] vout, input logic [16:0] vbat,
			input bit has_exp, input result_t want);
		int      gap;
		result_t res;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= {4'b0, vbat, vout, lvl_two, lvl_one};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		burst_left--;
		predict_relays(kind, lvl_one, lvl_two, vout, vbat, res);
		relay_expect_q.push_back(has_exp ? want : res);
	endtask

	// Registers change only once every outstanding result has drained.
	task automatic write_reg(input logic [1:0] idx, input logic [8:0] val);
		s_tvalid <= 1'b0;
		while (relay_expect_q.size() != 0)
			@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			REG_ARM_DELAY: model_cfg.arm_delay_ticks = val[7:0];
			REG_TIMEOUT:   model_cfg.precharge_timeout_ticks = val;
			REG_TOLERANCE: model_cfg.tolerance_tenths = val[3:0];
			default: begin
			end
		endcase
		burst_left = 0;
		@(posedge clk);
	endtask

	// Receiver backpressure alternates between patterns of random length.
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(READY_ALWAYS, READY_SPARSE);
			stall_left = $urandom_range(10, 80);
		end else begin
			stall_left--;
		end
		case (stall_mode)
			READY_ALWAYS: m_tready <= 1'b1;
			READY_COIN:   m_tready <= ($urandom_range(0, 1) == 1);
			default:      m_tready <= ($urandom_range(0, 3) == 0);
		endcase
	end

	// Compare each accepted result with the oldest expectation.
	always @(posedge clk) begin : relay_check
		result_t got;
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = relays(m_tdata[0], m_tdata[1], m_tdata[3:2], m_tdata[4], m_tdata[6:5]);
			if (relay_expect_q.size() == 0) begin
				fail_cnt++;
				if (fail_cnt <= REPORT_LIMIT)
					$display("unexpected result at cycle %0d: tdata=%h", cycle_cnt, m_tdata);
			end else begin
				want = relay_expect_q.pop_front();
				if (got !== want) begin
					fail_cnt++;
					if (fail_cnt <= REPORT_LIMIT)
						$display("mismatch at cycle %0d: main %b/%b pre %b/%b conn %0d/%0d ",
							cycle_cnt,
							want.main_relay_on, got.main_relay_on,
							want.precharge_relay_on, got.precharge_relay_on,
							want.connection, got.connection,
							"busy %b/%b outcome %0d/%0d (expected/actual)",
							want.precharging, got.precharging,
							want.switch_outcome, got.switch_outcome);
				end
			end
		end
	end

	// Watchdog against a hung handshake.
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("** precharge_contactor_sequencer_unit: FAILED **");
			$finish;
		end
	end

	initial begin : stimulus
		int unsigned ph_arm[NUM_PHASES] = '{0, 3, 255, 1, 0, 2};
		int unsigned ph_tmo[NUM_PHASES] = '{1, 8, 511, 0, 1, 4};
		int unsigned ph_tol[NUM_PHASES] = '{1, 10, 5, 0, 1, 15};
		int unsigned ph_items[NUM_PHASES] = '{50, 60, 400, 50, 50, 50};
		int          arm;
		int          tmo;
		int          tol;
		int          r;
		int          win;
		int          v;
		int          dwell_left;
		logic [1:0]  plug;
		bit          fresh;
		logic [2:0]  kind;
		logic        lvl_one;
		logic        lvl_two;
		logic [16:0] vout;
		logic [16:0] vbat;

		// Directed requests: reset values first, then the arm, boundary and timeout cases.
		add_row(KIND_TICK, 1, 1, 0, 0, 1, relays(0, 0, CONN_UNPLUGGED, 0, OUTCOME_NONE));
		add_row(KIND_CHG_EN, 1, 1, 0, 0, 1, relays(0, 0, CONN_UNPLUGGED, 0, OUTCOME_NONE));
		add_row(KIND_ON, 1, 1, 0, 0, 1, relays(1, 0, CONN_UNPLUGGED, 0, OUTCOME_ON));
		add_row(KIND_ON, 1, 1, 17'h1FFFF, 0, 1, relays(1, 0, CONN_UNPLUGGED, 0, OUTCOME_ON));
		add_row(KIND_TICK, 1, 1, 0, 0, 1, relays(1, 0, CONN_UNPLUGGED, 0, OUTCOME_NONE));
		add_row(KIND_OFF, 1, 1, 0, 0, 1, relays(0, 0, CONN_UNPLUGGED, 0, OUTCOME_NONE));
		add_row(KIND_ON, 0, 0, 0, 17'h1FFFF, 1, relays(0, 1, CONN_UNPLUGGED, 1, OUTCOME_NONE));
		add_row(KIND_OFF, 0, 0, 0, 0, 1, relays(0, 1, CONN_UNPLUGGED, 1, OUTCOME_NONE));
		add_row(KIND_TICK, 0, 0, 17'h1FFFF, 17'h1FFFF, 1,
			relays(1, 0, CONN_UNPLUGGED, 0, OUTCOME_ON));
		add_row(KIND_TICK, 0, 0, 0, 0, 1, relays(1, 0, CONN_CHARGER, 0, OUTCOME_NONE));
		add_row(KIND_CHG_DIS, 0, 0, 0, 0, 1, relays(0, 0, CONN_CHARGER, 0, OUTCOME_NONE));
		add_row(KIND_CHG_EN, 0, 0, 0, 0, 1, relays(1, 0, CONN_CHARGER, 0, OUTCOME_NONE));
		add_row(KIND_TICK, 0, 1, 0, 0, 1, relays(1, 0, CONN_CHARGER, 0, OUTCOME_NONE));
		add_row(KIND_RSVD_LO, 1, 1, 0, 0, 1, relays(1, 0, CONN_CHARGER, 0, OUTCOME_NONE));
		add_row(KIND_OFF, 0, 0, 0, 0, 1, relays(0, 0, CONN_CHARGER, 0, OUTCOME_NONE));
		add_row(KIND_TICK, 1, 0, 0, 0, 1, relays(0, 0, CONN_LOAD, 0, OUTCOME_NONE));
		add_cfg(REG_ARM_DELAY, 9'd0);
		add_cfg(REG_TIMEOUT, 9'd2);
		add_cfg(REG_TOLERANCE, 9'd9);
		add_row(KIND_TICK, 1, 0, 0, 1000, 0, '0);
		add_row(KIND_TICK, 1, 0, 100, 1000, 0, '0);
		add_row(KIND_OFF, 1, 0, 0, 0, 0, '0);
		add_row(KIND_TICK, 1, 0, 0, 1000, 0, '0);
		add_row(KIND_TICK, 1, 0, 0, 1000, 0, '0);
		add_row(KIND_TICK, 1, 0, 0, 1000, 0, '0);
		add_row(KIND_TICK, 1, 0, 1000, 1000, 0, '0);
		add_row(KIND_TICK, 1, 1, 0, 0, 0, '0);
		add_cfg(REG_TIMEOUT, 9'd0);
		add_row(KIND_ON, 1, 1, 0, 1000, 0, '0);
		add_row(KIND_TICK, 1, 1, 0, 1000, 0, '0);
		add_row(KIND_TICK, 1, 0, 1000, 1000, 0, '0);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (stim_table[i]) begin
			if (stim_table[i].is_cfg)
				write_reg(stim_table[i].reg_idx, stim_table[i].reg_val);
			else
				drive_request(stim_table[i].kind, stim_table[i].lvl_one, stim_table[i].lvl_two,
					stim_table[i].vout, stim_table[i].vbat, stim_table[i].has_exp,
					stim_table[i].exp_res);
		end

		// Random phases: plug states held for a while, voltages clustered around the window.
		dwell_left = 0;
		plug = CONN_UNPLUGGED;
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			arm = ph_arm[ph];
			tmo = ph_tmo[ph];
			tol = ph_tol[ph];
			if (ph == 4) begin
				arm = $urandom_range(0, 6);
				tmo = $urandom_range(1, 16);
				tol = $urandom_range(1, 10);
			end
			write_reg(REG_ARM_DELAY, 9'(arm));
			write_reg(REG_TIMEOUT, 9'(tmo));
			write_reg(REG_TOLERANCE, 9'(tol));
			fresh = 1'b1;
			dwell_left = 0;
			for (int n = 0; n < ph_items[ph]; n++) begin
				r = $urandom_range(0, 99);
				if (r < 72)
					kind = KIND_TICK;
				else if (r < 80)
					kind = KIND_ON;
				else if (r < 86)
					kind = KIND_OFF;
				else if (r < 91)
					kind = KIND_CHG_EN;
				else if (r < 96)
					kind = KIND_CHG_DIS;
				else
					kind = 3'($urandom_range(KIND_RSVD_LO, KIND_RSVD_HI));

				// A long dwell on a load lets the arm delay run out.
				if (kind == KIND_TICK) begin
					if (dwell_left == 0) begin
						if (fresh || $urandom_range(0, 1) == 1) begin
							plug = CONN_LOAD;
							dwell_left = $urandom_range(arm, arm + 12);
						end else begin
							r = $urandom_range(0, 99);
							plug = (r < 40) ? CONN_LOAD :
								(r < 70) ? CONN_CHARGER : CONN_UNPLUGGED;
							dwell_left = $urandom_range(1, 12);
						end
						fresh = 1'b0;
					end
					if (dwell_left > 0)
						dwell_left--;
				end
				case (plug)
					CONN_LOAD:    {lvl_one, lvl_two} = 2'b10;
					CONN_CHARGER: {lvl_one, lvl_two} = 2'b00;
					default:      {lvl_one, lvl_two} = 2'b11;
				endcase
				if (kind != KIND_TICK || $urandom_range(0, 99) < 8)
					{lvl_one, lvl_two} = 2'($urandom_range(0, 3));

				r = $urandom_range(0, 99);
				if (r < 10)
					vbat = '0;
				else if (r < 20)
					vbat = 17'h1FFFF;
				else
					vbat = 17'($urandom_range(0, 131071));
				r = $urandom_range(0, 99);
				if (r < 35) begin
					vout = 17'($urandom_range(0, 131071));
				end else if (r < 45) begin
					vout = vbat;
				end else begin
					win = (int'(vbat) * tol) / 10;
					v = $urandom_range(0, win + win / 4 + 2);
					v = ($urandom_range(0, 1) == 1) ? int'(vbat) + v : int'(vbat) - v;
					if (v < 0)
						v = 0;
					if (v > 131071)
						v = 131071;
					vout = 17'(v);
				end
				drive_request(kind, lvl_one, lvl_two, vout, vbat, 1'b0, '0);
			end
		end

		// Drain, allow the pipeline to settle, then report.
		s_tvalid <= 1'b0;
		while (relay_expect_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (fail_cnt == 0 && relay_expect_q.size() == 0)
			$display("** precharge_contactor_sequencer_unit: PASSED **");
		else
			$display("** precharge_contactor_sequencer_unit: FAILED **");
		$finish;
	end

endmodule
